>>> rtl/core/sle_pkg.sv
// Shared types, constants and the 4B5B code table for the selectable line encoder.
package sle_pkg;

  localparam int unsigned SymW = 16;                 // widest pattern (Manchester)
  localparam int unsigned CntW = $clog2(SymW + 1);

  typedef enum logic [1:0] {
    ModeNrz        = 2'd0,
    ModeManchester = 2'd1,
    ModeNrzi       = 2'd2,
    Mode4b5b       = 2'd3
  } line_mode_e;

  localparam logic [CntW-1:0] LenNrz        = CntW'(8);
  localparam logic [CntW-1:0] LenManchester = CntW'(16);
  localparam logic [CntW-1:0] LenNrzi       = CntW'(8);
  localparam logic [CntW-1:0] Len4b5b       = CntW'(10);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic line_bit;
    logic last_of_byte;
  } out_t;

  function automatic logic [4:0] code_4b5b(input logic [3:0] nib);
    logic [4:0] c;
    unique case (nib)
      4'h0: c = 5'h1E;
      4'h1: c = 5'h09;
      4'h2: c = 5'h14;
      4'h3: c = 5'h15;
      4'h4: c = 5'h0A;
      4'h5: c = 5'h0B;
      4'h6: c = 5'h0E;
      4'h7: c = 5'h0F;
      4'h8: c = 5'h12;
      4'h9: c = 5'h13;
      4'hA: c = 5'h16;
      4'hB: c = 5'h17;
      4'hC: c = 5'h1A;
      4'hD: c = 5'h1B;
      4'hE: c = 5'h1C;
      default: c = 5'h1D;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/selectable_line_encoder.sv
// Selectable line encoder: byte in, NRZ / Manchester / NRZI / 4B5B line bits out.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one data byte per word with an
// end-of-message flag. Output channel (out_valid_o/out_ready_i/out_data_o) gives one line
// bit per word, MSB first, with last_of_byte set on the final bit of each byte.
// cfg_valid_i/cfg_data_i write the 2-bit line mode (0 NRZ, 1 Manchester, 2 NRZI, 3 4B5B);
// cfg_ready_o is always high. Change the mode only while the encoder is drained.
// Each byte yields 8 (NRZ, NRZI), 16 (Manchester) or 10 (4B5B) output words; the output
// port runs at one bit per cycle while out_ready_i is high. When the encoder is empty,
// an accepted byte passes through the hold register and then the shift register to the
// output. The encode runs in the accept cycle into a one-entry hold register; a shift
// register feeds the output. The next byte is taken while the current one is still
// shifting out, so bytes follow with no gap between their bits.
// When the receiver stalls, the shift register holds, the hold register fills and
// in_ready_o drops. Reset clears the mode to NRZ, the NRZI level to 0 and empties both
// stages.
module selectable_line_encoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sle_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sle_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_data_i
);

  sle_pkg::line_mode_e          mode_q;
  logic                         nrzi_q, nrzi_d;
  logic                         hold_valid_q;
  logic [sle_pkg::SymW-1:0]     hold_pat_q, pat_d;
  logic [sle_pkg::CntW-1:0]     hold_len_q, len_d;
  logic [sle_pkg::SymW-1:0]     sh_q;
  logic [sle_pkg::CntW-1:0]     cnt_q;
  logic                         hold_take, in_acc;
  logic [7:0]                   d;
  logic [7:0]                   nrzi_bits;
  logic                         lvl;

  assign cfg_ready_o = 1'b1;
  // serializer can take the held pattern when empty or on its last bit leaving
  assign hold_take   = hold_valid_q &&
                       ((cnt_q == '0) || ((cnt_q == sle_pkg::CntW'(1)) && out_ready_i));
  assign in_ready_o  = !hold_valid_q || hold_take;
  assign in_acc      = in_valid_i && in_ready_o;

  assign out_valid_o             = (cnt_q != '0);
  assign out_data_o.line_bit     = sh_q[sle_pkg::SymW-1];
  assign out_data_o.last_of_byte = (cnt_q == sle_pkg::CntW'(1));

  assign d = in_data_i.data_byte;

  // encode, patterns left justified
  always_comb begin
    pat_d = '0;
    len_d = sle_pkg::LenNrz;
    lvl   = nrzi_q;
    nrzi_bits = '0;
    for (int i = 7; i >= 0; i--) begin
      lvl = lvl ^ d[i];
      nrzi_bits[i] = lvl;
    end
    unique case (mode_q)
      sle_pkg::ModeNrz: begin
        pat_d[sle_pkg::SymW-1 -: 8] = d;
        len_d = sle_pkg::LenNrz;
      end
      sle_pkg::ModeManchester: begin
        for (int k = 0; k < 8; k++) begin
          pat_d[sle_pkg::SymW-1-2*k] = d[7-k];
          pat_d[sle_pkg::SymW-2-2*k] = ~d[7-k];
        end
        len_d = sle_pkg::LenManchester;
      end
      sle_pkg::ModeNrzi: begin
        pat_d[sle_pkg::SymW-1 -: 8] = nrzi_bits;
        len_d = sle_pkg::LenNrzi;
      end
      default: begin
        pat_d[sle_pkg::SymW-1 -: 10] = {sle_pkg::code_4b5b(d[7:4]),
                                        sle_pkg::code_4b5b(d[3:0])};
        len_d = sle_pkg::Len4b5b;
      end
    endcase
    if (in_data_i.end_of_message) begin
      nrzi_d = 1'b0;
    end else if (mode_q == sle_pkg::ModeNrzi) begin
      nrzi_d = lvl;
    end else begin
      nrzi_d = nrzi_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= sle_pkg::ModeNrz;
      nrzi_q       <= 1'b0;
      hold_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= sle_pkg::line_mode_e'(cfg_data_i);
      end
      if (in_acc) begin
        nrzi_q       <= nrzi_d;
        hold_valid_q <= 1'b1;
      end else if (hold_take) begin
        hold_valid_q <= 1'b0;
      end
      if (hold_take) begin
        cnt_q <= hold_len_q;
      end else if (out_valid_o && out_ready_i) begin
        cnt_q <= cnt_q - sle_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_pat_q <= pat_d;
      hold_len_q <= len_d;
    end
    if (hold_take) begin
      sh_q <= hold_pat_q;
    end else if (out_valid_o && out_ready_i) begin
      sh_q <= {sh_q[sle_pkg::SymW-2:0], 1'b0};
    end
  end

`ifndef SYNTHESIS
  a_hold_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_valid_q && cnt_q == '0) |=> (cnt_q != '0))
    else $error("held pattern not moved into empty serializer");

  a_eom_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_message) |=> (nrzi_q == 1'b0))
    else $error("NRZI level not cleared after end of message");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sle_pkg::CntW'(sle_pkg::SymW))
    else $error("serializer count out of range");
`endif

endmodule

>>> sim/selectable_line_encoder_test.sv
// Self-checking testbench for the selectable line encoder: all four line codes, random stalls.
module selectable_line_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned PhaseItems = 36;

  localparam logic [4:0] Sym4b5b [16] = '{
    5'h1E, 5'h09, 5'h14, 5'h15, 5'h0A, 5'h0B, 5'h0E, 5'h0F,
    5'h12, 5'h13, 5'h16, 5'h17, 5'h1A, 5'h1B, 5'h1C, 5'h1D
  };

  localparam sle_pkg::line_mode_e PhaseModes [12] = '{
    sle_pkg::ModeManchester, sle_pkg::Mode4b5b, sle_pkg::ModeNrz, sle_pkg::ModeNrzi,
    sle_pkg::Mode4b5b, sle_pkg::ModeNrzi, sle_pkg::ModeNrz, sle_pkg::ModeManchester,
    sle_pkg::ModeNrzi, sle_pkg::Mode4b5b, sle_pkg::ModeNrz, sle_pkg::ModeNrzi
  };

  logic          clk_i     = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready_o;
  sle_pkg::in_t  in_data   = '0;
  logic          out_valid_o;
  logic          out_ready = 1'b0;
  sle_pkg::out_t out_data_o;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_data  = 2'd0;

  selectable_line_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state, touched only by the monitor; byte_queue is filled by send and emptied by the driver
  sle_pkg::line_mode_e cur_mode   = sle_pkg::ModeNrz;
  logic                nrzi_level = 1'b0;
  sle_pkg::out_t       expected_bits [$];
  sle_pkg::in_t        byte_queue [$];

  int unsigned mismatches  = 0;
  int unsigned bits_seen   = 0;
  int unsigned eom_seen    = 0;
  int unsigned bytes_per_mode [4] = '{0, 0, 0, 0};
  int unsigned cycles      = 0;

  logic [2:0]  gap_left    = '0;
  logic [2:0]  stall_left  = '0;
  bit          in_calm     = 1'b0;
  bit          out_calm    = 1'b0;

  function automatic void encode_byte(input sle_pkg::in_t w);
    logic [15:0]   bits;
    int            n;
    int            i;
    sle_pkg::out_t r;
    bits = '0;
    case (cur_mode)
      sle_pkg::ModeNrz: begin
        bits[15:8] = w.data_byte;
        n = 8;
      end
      sle_pkg::ModeManchester: begin
        for (i = 0; i < 8; i++) begin
          bits[15-2*i] = w.data_byte[7-i];
          bits[14-2*i] = ~w.data_byte[7-i];
        end
        n = 16;
      end
      sle_pkg::ModeNrzi: begin
        for (i = 0; i < 8; i++) begin
          if (w.data_byte[7-i]) nrzi_level = ~nrzi_level;
          bits[15-i] = nrzi_level;
        end
        n = 8;
      end
      default: begin
        bits[15:6] = {Sym4b5b[w.data_byte[7:4]], Sym4b5b[w.data_byte[3:0]]};
        n = 10;
      end
    endcase
    for (i = 0; i < n; i++) begin
      r.line_bit     = bits[15-i];
      r.last_of_byte = (i == n - 1);
      expected_bits.push_back(r);
    end
    if (w.end_of_message) nrzi_level = 1'b0;
  endfunction

  // driver: one word per handshake, random gap after each word
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= '0;
    end else if (!in_valid || in_ready_o) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 3'd1;
      end else if (byte_queue.size() != 0) begin
        in_data  <= byte_queue.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 15) == 0) in_calm = ~in_calm;
        gap_left <= in_calm ? 3'd0 : 3'($urandom_range(0, 7));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: tracks config and accepted bytes, checks each line bit, throttles out_ready
  always @(posedge clk_i or negedge rst_n) begin
    sle_pkg::out_t got;
    sle_pkg::out_t want;
    logic [2:0]    s;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= '0;
    end else begin
      if (cfg_valid && cfg_ready_o) cur_mode = sle_pkg::line_mode_e'(cfg_data);
      if (in_valid && in_ready_o) begin
        bytes_per_mode[cur_mode]++;
        if (in_data.end_of_message) eom_seen++;
        encode_byte(in_data);
      end
      if (out_valid_o && out_ready) begin
        got = out_data_o;
        bits_seen++;
        if (expected_bits.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("unexpected word %0d: line_bit %b last_of_byte %b",
                     bits_seen, got.line_bit, got.last_of_byte);
        end else begin
          want = expected_bits.pop_front();
          if (got.line_bit !== want.line_bit || got.last_of_byte !== want.last_of_byte) begin
            mismatches++;
            if (mismatches <= ReportMax)
              $display("word %0d: line_bit exp %b got %b, last_of_byte exp %b got %b",
                       bits_seen, want.line_bit, got.line_bit,
                       want.last_of_byte, got.last_of_byte);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 3'd1;
        out_ready  <= (stall_left == 3'd1);
      end else if (!out_ready) begin
        out_ready <= 1'b1;
      end else if (out_valid_o) begin
        if ($urandom_range(0, 31) == 0) out_calm = ~out_calm;
        s = out_calm ? 3'd0 : 3'($urandom_range(0, 7));
        stall_left <= s;
        out_ready  <= (s == 3'd0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, expected_bits.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(input logic [7:0] b, input logic eom);
    sle_pkg::in_t w;
    w.data_byte      = b;
    w.end_of_message = eom;
    byte_queue.push_back(w);
  endtask

  // wait until every queued byte is in and every line bit is out
  task automatic drain();
    do @(negedge clk_i);
    while (byte_queue.size() != 0 || in_valid || expected_bits.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mode(input sle_pkg::line_mode_e m);
    drain();
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned p;
    int unsigned k;
    logic [7:0]  b;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // NRZ from reset, extremes
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h80, 1'b1);
    // Manchester polarity
    write_mode(sle_pkg::ModeManchester);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'hA5, 1'b1);
    // NRZI, message left open with level high
    write_mode(sle_pkg::ModeNrzi);
    send(8'hFF, 1'b0);
    send(8'h01, 1'b0);
    send(8'h00, 1'b0);
    // every 4B5B nibble; level must survive the mode switch
    write_mode(sle_pkg::Mode4b5b);
    for (k = 0; k < 8; k++) send(8'((2 * k) << 4 | (2 * k + 1)), 1'b0);
    write_mode(sle_pkg::ModeNrzi);
    send(8'h00, 1'b0);
    send(8'h03, 1'b0);
    // end of message outside NRZI still clears the level
    write_mode(sle_pkg::Mode4b5b);
    send(8'h5A, 1'b1);
    write_mode(sle_pkg::ModeNrzi);
    send(8'h00, 1'b1);

    for (p = 0; p < $size(PhaseModes); p++) begin
      write_mode(PhaseModes[p]);
      for (k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 19))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send(b, $urandom_range(0, 5) == 0);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);

    $display("bytes NRZ %0d, Manchester %0d, NRZI %0d, 4B5B %0d; %0d message ends",
             bytes_per_mode[sle_pkg::ModeNrz], bytes_per_mode[sle_pkg::ModeManchester],
             bytes_per_mode[sle_pkg::ModeNrzi], bytes_per_mode[sle_pkg::Mode4b5b], eom_seen);
    $display("%0d line bits checked, %0d mismatches", bits_seen, mismatches);
    if (mismatches == 0 && expected_bits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/sle_pkg.sv
rtl/core/selectable_line_encoder.sv
sim/selectable_line_encoder_test.sv
